// ===== rtl/kbt_pkg.sv =====
// Shared types, fixed-point constants and helpers for the box tracker.
package kbt_pkg;

  localparam int TDATA_W   = 96;
  localparam int CFG_IDX_W = 8;
  localparam int ACC_W     = 68;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

  // Q16.16 coefficients.
  localparam logic signed [31:0] DT_Q16    = 32'sd13107;
  localparam logic signed [31:0] DAMP_Q16  = 32'sd58982;
  localparam logic signed [31:0] ALPHA_Q16 = 32'sd52429;
  localparam logic signed [31:0] BETA_Q16  = 32'sd13107;
  // Q8.24 noise terms.
  localparam logic signed [31:0] QPOS_Q24  = 32'sd1677722;
  localparam logic signed [31:0] QVEL_Q24  = 32'sd838861;
  localparam logic signed [31:0] RMEAS_Q24 = 32'sd838861;
  localparam logic signed [31:0] ONE_Q24   = 32'sd16777216;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_PRE, ST_COV, ST_S, ST_DET, ST_INV,
    ST_KG, ST_POST, ST_PCOV, ST_BLEND, ST_OUT
  } st_t;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} div_st_t;

  typedef enum logic [1:0] {PSH_NONE, PSH_R16, PSH_R24, PSH_L21} psh_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-32){1'b0}}, S32_MAX};
    lo = {{(ACC_W-32){1'b1}}, S32_MIN};
    if (v > hi) return S32_MAX;
    if (v < lo) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] ext32(input logic signed [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

endpackage

// ===== rtl/kbt_mul.sv =====
// Shared signed 32x32 multiplier with a registered product.
module kbt_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

// ===== rtl/kbt_div.sv =====
// Bit-serial signed divider: saturated 32-bit quotient of (num * 2^24) / den.
module kbt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [32:0]        num,
  input  logic signed [40:0]        den,
  output logic signed [31:0]        quot,
  output kbt_pkg::div_stat_t        stat
);
  import kbt_pkg::*;

  div_st_t     dst, dst_next;
  logic [5:0]  cnt;
  logic [56:0] nmag;
  logic [40:0] dmag;
  logic [40:0] rem;
  logic        qneg, nneg, nzero, zden;
  logic [41:0] trial, diff;
  logic        ge;
  logic [32:0] num_abs;
  logic [40:0] den_abs;

  assign num_abs = num[32] ? 33'(-num) : 33'(num);
  assign den_abs = den[40] ? 41'(-den) : 41'(den);
  assign trial   = {rem, nmag[56]};
  assign diff    = trial - {1'b0, dmag};
  assign ge      = (trial >= {1'b0, dmag});

  always_comb begin
    dst_next = dst;
    case (dst)
      DV_IDLE: if (start) dst_next = (den == '0) ? DV_DONE : DV_RUN;
      DV_RUN:  if (cnt == '0) dst_next = DV_DONE;
      DV_DONE: dst_next = DV_IDLE;
      default: dst_next = DV_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (dst != DV_IDLE);
    stat.done = (dst == DV_DONE);
    if (zden) begin
      quot = nzero ? 32'sd0 : (nneg ? S32_MIN : S32_MAX);
    end else if (qneg) begin
      quot = (nmag > 57'h80000000) ? S32_MIN : 32'(-nmag[31:0]);
    end else begin
      quot = (nmag > 57'h7FFFFFFF) ? S32_MAX : nmag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst <= DV_IDLE;
    end else begin
      dst <= dst_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dst == DV_IDLE && start) begin
      nmag  <= {num_abs[32:0], 24'b0};
      dmag  <= den_abs;
      rem   <= '0;
      cnt   <= 6'd56;
      qneg  <= num[32] ^ den[40];
      nneg  <= num[32];
      nzero <= (num == '0);
      zden  <= (den == '0);
    end else if (dst == DV_RUN) begin
      rem  <= ge ? diff[40:0] : trial[40:0];
      nmag <= {nmag[55:0], ge};
      cnt  <= cnt - 6'd1;
    end
  end
endmodule

// ===== rtl/kalman_box_tracker_top.sv =====
// Top level of the box tracker: handshakes, state registers and the step sequencer.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   box_x, box_y, box_w, box_h
//  m_axis    out        m_axis_tvalid/m_axis_tready   out_x, out_y, out_w, out_h
//  cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// Most of the work from input transaction to result is the bit-serial divider,
// which forms the four entries of the 2x2 inverse one after another; the rest
// is the single shared multiplier, whose every product has an issue phase and
// an accumulate phase, and the one-term-a-cycle covariance prediction.
// A box that arrives before tracking starts and is missing is passed through
// unchanged. The input is ready only while the sequencer is idle. A finished
// result sits in the output register until taken, and the next input is accepted
// meanwhile; its result waits in the final state until the register is free.
// Reset (synchronous, active high) restores the frame registers to 640x480 and
// arms the tracker for its first valid box; no clearing pass is needed.
module kalman_box_tracker_top #(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // box_x[23:0], box_y[47:24], box_w[70:48], box_h[93:71], zeros above
  input  logic [kbt_pkg::TDATA_W-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_x[23:0], out_y[47:24], out_w[70:48], out_h[93:71], zeros above
  output logic [kbt_pkg::TDATA_W-1:0]      m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);
  import kbt_pkg::*;

  localparam int SC = 16 - COORD_FRAC_BITS;

  st_t st, st_next;
  logic        started;
  logic [15:0] fw, fh;

  // Captured item.
  logic signed [23:0] bx, by;
  logic [22:0]        bw, bh;
  logic               miss, pass;

  // Filter state and scratch registers.
  logic signed [31:0] trk [4];
  logic signed [31:0] cov [16];
  logic signed [31:0] pp [16];
  logic signed [31:0] pre [4];
  logic signed [31:0] kg [8];
  logic signed [31:0] post [4];
  logic signed [31:0] inv [4];
  logic signed [31:0] zv [2];
  logic signed [31:0] ev [2];
  logic signed [23:0] prv [2];
  logic signed [31:0] s00, s11;
  logic signed [40:0] dq;
  logic signed [ACC_W-1:0] acc;

  // Sequencer counters: entry, term within entry, issue/accumulate phase.
  logic [3:0] ent;
  logic [1:0] trm;
  logic       ph;

  // Datapath controls.
  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] base_val, term, addv, sum;
  psh_t                    psh;
  logic                    neg;
  logic [1:0]              trm_last;
  logic [3:0]              ent_last;
  logic [3:0]              pp_ra, cov_ra;
  logic                    cov_ok;
  logic signed [31:0]      pp_rd, cov_rd;
  logic                    mstate, step_done, last_step, phase_end;

  logic                    in_fire, in_missing, out_load;
  logic                    div_start;
  logic signed [32:0]      div_num;
  logic signed [31:0]      div_q;
  div_stat_t               div_stat;

  logic signed [ACC_W-1:0] bxs, bys;
  logic signed [31:0]      zc [2];
  logic signed [41:0]      pscl, dd;
  logic signed [31:0]      dl, dh;
  logic signed [31:0]      ox32, oy32;
  logic signed [33:0]      ux, uy, cx, cy;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign in_missing = (s_axis_tdata[70:48] == '0) || (s_axis_tdata[93:71] == '0);
  assign cfg_ready  = 1'b1;
  assign pp_rd      = pp[pp_ra];
  assign cov_rd     = cov[cov_ra];

  assign mstate = (st == ST_PRE) || (st == ST_DET) || (st == ST_KG) ||
                  (st == ST_POST) || (st == ST_PCOV) || (st == ST_BLEND);
  assign step_done = (st == ST_COV) || (mstate && ph);
  assign last_step = step_done && (trm == trm_last);
  assign phase_end = last_step && (ent == ent_last);

  kbt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  kbt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dq),
    .quot  (div_q),
    .stat  (div_stat)
  );

  // Scaled measurement and the blend difference against the previous corner.
  always_comb begin
    bxs   = {{(ACC_W-24){bx[23]}}, bx} <<< SC;
    bys   = {{(ACC_W-24){by[23]}}, by} <<< SC;
    zc[0] = miss ? pre[0] : sat32(bxs);
    zc[1] = miss ? pre[1] : sat32(bys);
    pscl  = {{18{prv[ent[0]][23]}}, prv[ent[0]]} <<< SC;
    dd    = {{10{zv[ent[0]][31]}}, zv[ent[0]]} - pscl;
    dl    = {11'b0, dd[20:0]};
    dh    = {{11{dd[41]}}, dd[41:21]};
  end

  // Operand selection for the current step.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    base_val = '0;
    psh      = PSH_NONE;
    neg      = 1'b0;
    trm_last = 2'd0;
    ent_last = 4'd0;
    pp_ra    = ent;
    cov_ra   = '0;
    cov_ok   = 1'b0;
    div_num  = '0;
    case (st)
      ST_PRE: begin
        // Position: p + v + v*dt; velocity: v*damp.
        mul_a    = trk[{1'b1, ent[0]}];
        mul_b    = ent[1] ? DAMP_Q16 : DT_Q16;
        base_val = ent[1] ? '0 : ext32(trk[{1'b0, ent[0]}]) + ext32(trk[{1'b1, ent[0]}]);
        psh      = PSH_R16;
        ent_last = 4'd3;
      end
      ST_COV: begin
        cov_ra   = {(trm[0] ? {1'b1, ent[2]} : ent[3:2]),
                    (trm[1] ? {1'b1, ent[0]} : ent[1:0])};
        cov_ok   = (!trm[0] || !ent[3]) && (!trm[1] || !ent[1]);
        if (ent[3:2] == ent[1:0]) base_val = ext32(ent[3] ? QVEL_Q24 : QPOS_Q24);
        trm_last = 2'd3;
        ent_last = 4'd15;
      end
      ST_DET: begin
        mul_a    = trm[0] ? pp[1] : s00;
        mul_b    = trm[0] ? pp[4] : s11;
        neg      = trm[0];
        trm_last = 2'd1;
      end
      ST_INV: begin
        case (ent[1:0])
          2'd0:    div_num = {s11[31], s11};
          2'd1:    div_num = 33'(-{pp[1][31], pp[1]});
          2'd2:    div_num = 33'(-{pp[4][31], pp[4]});
          default: div_num = {s00[31], s00};
        endcase
      end
      ST_KG: begin
        pp_ra    = {ent[2:1], 1'b0, trm[0]};
        mul_a    = pp_rd;
        mul_b    = inv[{trm[0], ent[0]}];
        psh      = PSH_R24;
        trm_last = 2'd1;
        ent_last = 4'd7;
      end
      ST_POST: begin
        mul_a    = kg[{ent[1:0], trm[0]}];
        mul_b    = ev[trm[0]];
        base_val = ext32(pre[ent[1:0]]);
        psh      = PSH_R24;
        trm_last = 2'd1;
        ent_last = 4'd3;
      end
      ST_PCOV: begin
        // Issue reads row t of P'; accumulate reads the entry being updated.
        pp_ra    = ph ? ent : {1'b0, trm[0], ent[1:0]};
        mul_a    = kg[{ent[3:2], trm[0]}];
        mul_b    = pp_rd;
        base_val = ext32(pp_rd);
        neg      = 1'b1;
        psh      = PSH_R24;
        trm_last = 2'd1;
        ent_last = 4'd15;
      end
      ST_BLEND: begin
        // The difference is split in two so that it fits the multiplier.
        case (trm)
          2'd0:    mul_a = dl;
          2'd1:    mul_a = dh;
          default: mul_a = post[{1'b1, ent[0]}];
        endcase
        mul_b    = (trm == 2'd2) ? BETA_Q16 : ALPHA_Q16;
        psh      = (trm == 2'd1) ? PSH_L21 : PSH_NONE;
        trm_last = 2'd2;
        ent_last = 4'd1;
      end
      default: begin
      end
    endcase
  end

  // Shared accumulator.
  always_comb begin
    if (st == ST_COV) begin
      term = cov_ok ? ext32(cov_rd) : '0;
    end else begin
      case (psh)
        PSH_R16: term = {{(ACC_W-48){prod[63]}}, prod[63:16]};
        PSH_R24: term = {{(ACC_W-40){prod[63]}}, prod[63:24]};
        PSH_L21: term = {prod[ACC_W-22:0], 21'b0};
        default: term = {{(ACC_W-64){prod[63]}}, prod};
      endcase
    end
    addv = neg ? -term : term;
    sum  = ((trm == 2'd0) ? base_val : acc) + addv;
  end

  // Output clamp against the frame.
  always_comb begin
    ox32 = pre[0] >>> SC;
    oy32 = pre[1] >>> SC;
    ux   = $signed({2'b0, 32'(32'(fw) << COORD_FRAC_BITS)}) - $signed({11'b0, bw});
    uy   = $signed({2'b0, 32'(32'(fh) << COORD_FRAC_BITS)}) - $signed({11'b0, bh});
    cx   = {{2{ox32[31]}}, ox32};
    cy   = {{2{oy32[31]}}, oy32};
    if (cx > ux) cx = ux;
    if (cx < 34'sd0) cx = '0;
    if (cx > 34'sd8388607) cx = 34'sd8388607;
    if (cy > uy) cy = uy;
    if (cy < 34'sd0) cy = '0;
    if (cy > 34'sd8388607) cy = 34'sd8388607;
  end

  // Next state.
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (in_fire) begin
          if (!started && in_missing) st_next = ST_OUT;
          else if (!started) st_next = ST_INIT;
          else st_next = ST_PRE;
        end
      end
      ST_INIT:  st_next = ST_PRE;
      ST_PRE:   if (phase_end) st_next = ST_COV;
      ST_COV:   if (phase_end) st_next = ST_S;
      ST_S:     st_next = ST_DET;
      ST_DET:   if (phase_end) st_next = ST_INV;
      ST_INV:   if (ph && div_stat.done && ent[1:0] == 2'd3) st_next = ST_KG;
      ST_KG:    if (phase_end) st_next = ST_POST;
      ST_POST:  if (phase_end) st_next = ST_PCOV;
      ST_PCOV:  if (phase_end) st_next = ST_BLEND;
      ST_BLEND: if (phase_end) st_next = ST_OUT;
      ST_OUT:   if (!m_axis_tvalid || m_axis_tready) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = (st == ST_IDLE);
    div_start     = (st == ST_INV) && !ph;
    out_load      = (st == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      started       <= 1'b0;
      fw            <= 16'd640;
      fh            <= 16'd480;
      m_axis_tvalid <= 1'b0;
      ent           <= '0;
      trm           <= '0;
      ph            <= 1'b0;
    end else begin
      st <= st_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_WIDTH) fw <= cfg_data;
        if (cfg_index == CFG_FRAME_HEIGHT) fh <= cfg_data;
      end
      if (st == ST_INIT) started <= 1'b1;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (st_next != st) begin
        ent <= '0;
        trm <= '0;
        ph  <= 1'b0;
      end else if (st == ST_INV) begin
        if (!ph) begin
          ph <= 1'b1;
        end else if (div_stat.done) begin
          ph  <= 1'b0;
          ent <= ent + 4'd1;
        end
      end else if (st == ST_COV || mstate) begin
        if (mstate && !ph) begin
          ph <= 1'b1;
        end else begin
          ph <= 1'b0;
          if (trm == trm_last) begin
            trm <= '0;
            ent <= ent + 4'd1;
          end else begin
            trm <= trm + 2'd1;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bx   <= s_axis_tdata[23:0];
      by   <= s_axis_tdata[47:24];
      bw   <= s_axis_tdata[70:48];
      bh   <= s_axis_tdata[93:71];
      miss <= in_missing;
      pass <= !started && in_missing;
    end
    if (st == ST_INIT) begin
      trk[0] <= sat32(bxs);
      trk[1] <= sat32(bys);
      trk[2] <= '0;
      trk[3] <= '0;
      prv[0] <= bx;
      prv[1] <= by;
      for (int k = 0; k < 16; k++) cov[k] <= (k % 5 == 0) ? ONE_Q24 : '0;
    end
    if (step_done) acc <= sum;
    if (st == ST_S) begin
      s00   <= sat32(ext32(pp[0]) + ext32(RMEAS_Q24));
      s11   <= sat32(ext32(pp[5]) + ext32(RMEAS_Q24));
      zv[0] <= zc[0];
      zv[1] <= zc[1];
      ev[0] <= sat32(ext32(zc[0]) - ext32(pre[0]));
      ev[1] <= sat32(ext32(zc[1]) - ext32(pre[1]));
    end
    if (st == ST_INV && ph && div_stat.done) inv[ent[1:0]] <= div_q;
    if (last_step) begin
      case (st)
        ST_PRE:  pre[ent[1:0]] <= sat32(sum);
        ST_COV:  pp[ent] <= sat32(sum);
        ST_DET:  dq <= 41'(sum >>> 24);
        ST_KG:   kg[ent[2:0]] <= sat32(sum);
        ST_POST: post[ent[1:0]] <= sat32(sum);
        ST_PCOV: cov[ent] <= sat32(sum);
        ST_BLEND: begin
          trk[{1'b1, ent[0]}] <= sat32(sum >>> 16);
          trk[{1'b0, ent[0]}] <= post[{1'b0, ent[0]}];
          if (ent[0]) begin
            prv[0] <= bx;
            prv[1] <= by;
          end
        end
        default: begin
        end
      endcase
    end
    if (out_load) begin
      if (pass) m_axis_tdata <= {2'b0, bh, bw, by, bx};
      else m_axis_tdata <= {2'b0, bh, bw, cy[23:0], cx[23:0]};
    end
  end

  // A missing box before the first detection goes straight to the result.
  a_pass_direct: assert property (@(posedge clk) disable iff (rst)
    in_fire && !started && in_missing |=> st == ST_OUT)
    else $error("pass-through item did not go to output");

  // Once tracking has started it never stops until reset.
  a_started_sticks: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("tracking flag dropped");

  // The sequencer starts a division only when the divider is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("division started while divider busy");

  // A new result appears only from the final state.
  a_out_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(st == ST_OUT))
    else $error("result raised outside output state");

endmodule
